// ===== rtl/page_span_allocator_assert.svh =====
// Assertion macros shared by the page span allocator checkers.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef PAGE_SPAN_ALLOCATOR_ASSERT_SVH
`define PAGE_SPAN_ALLOCATOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define PSA_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define PSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/psa_pkg.sv =====
// Package for the page span allocator: codes, field widths and state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 8;
    localparam int PAGE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int START_W  = 12;
    localparam int PAGES_W  = 8;
    localparam int LIMIT_W  = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_PAGES  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_HEAD,
        ST_RM_RD,
        ST_RM_WR,
        ST_MARK,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_PUSH_LINK,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_FREE_PQ,
        ST_FREE_PL,
        ST_FREE_NX,
        ST_FREE_NL,
        ST_LOOK_RD,
        ST_LOOK_OW,
        ST_LOOK_LU,
        ST_DONE
    } psa_state_t;

    // Where a list removal continues.
    typedef enum logic [1:0] {
        RM_TO_AMARK,
        RM_TO_FNX,
        RM_TO_FMARK
    } rm_ret_t;

    // Where a page map sweep continues.
    typedef enum logic [1:0] {
        MK_TO_DONE,
        MK_TO_REM,
        MK_TO_PUSH
    } mk_ret_t;

endpackage

`default_nettype wire

// ===== rtl/psa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the old contents on a same-address collision.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/page_span_allocator.sv =====
// Top level of the page span allocator: sequencer, registers and page/list memories.
// Depends on psa_pkg and psa_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------
//  request   | start, busy          | action, req_pages, page_number
//  result    | done (one cycle)     | status, run_start, run_pages
//  config    | cfg_we               | cfg_wdata (fresh page limit)
//
// One request at a time; busy is high from the accepting edge until done.
// Allocate scans the per-length free lists one length a cycle (up to MAX_RUN), then
// sweeps the page map one page a cycle over the taken run, or over the whole run it splits.
// Free sweeps the merged run's pages (up to MAX_RUN).
// The owner memory port, one write a cycle, sets the sweep length.
// No clearing pass: mapped pages are exactly those below the bump pointer.
`timescale 1ns / 1ps
`default_nettype none

module page_span_allocator
    import psa_pkg::*;
#(
    parameter int MAX_RUN    = 128,
    parameter int POOL_PAGES = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [COUNT_W-1:0]  req_pages,
    input  wire logic [PAGE_W-1:0]   page_number,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [START_W-1:0]       run_start,
    output logic [PAGES_W-1:0]       run_pages,
    input  wire logic                cfg_we,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata
);

    localparam int PW = $clog2(POOL_PAGES);
    localparam int LW = PW + 1;
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int SW = ((LW > CW) ? LW : CW) + 1;
    localparam int BW = ((LW > LIMIT_W) ? LW : LIMIT_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_PAGES);

    // Control registers.
    psa_state_t          state_reg, state_next;
    logic [MAX_RUN:0]    nonempty_reg, nonempty_next;
    logic [LW-1:0]       fresh_reg, fresh_next;
    logic [LIMIT_W-1:0]  limit_reg;

    // Working registers.
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [PW-1:0]       pg_reg, pg_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [PW-1:0]       s_reg, s_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [PW-1:0]       q_reg, q_next;
    logic [PW-1:0]       rs_reg, rs_next;
    logic [CW-1:0]       rlen_reg, rlen_next;
    rm_ret_t             ret_reg, ret_next;
    logic [PW-1:0]       ms_reg, ms_next;
    logic [CW-1:0]       mlen_reg, mlen_next;
    logic                mused_reg, mused_next;
    logic [CW-1:0]       k_reg, k_next;
    mk_ret_t             mret_reg, mret_next;
    logic [PW-1:0]       ps_reg, ps_next;
    logic [CW-1:0]       plen_reg, plen_next;
    logic [LW-1:0]       t_reg, t_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [START_W-1:0]  res_start_reg, res_start_next;
    logic [PAGES_W-1:0]  res_pages_reg, res_pages_next;

    // Memory ports.
    logic          own_we;
    logic [PW-1:0] own_waddr, own_wdata, own_raddr, own_rd;
    logic          lu_we;
    logic [PW-1:0] lu_waddr, lu_raddr;
    logic [CW:0]   lu_wdata, lu_rd;
    logic          nx_we;
    logic [PW-1:0] nx_waddr, nx_raddr;
    logic [LW-1:0] nx_wdata, nx_rd;
    logic          pv_we;
    logic [PW-1:0] pv_waddr, pv_raddr;
    logic [LW-1:0] pv_wdata, pv_rd;
    logic          hd_we;
    logic [CW-1:0] hd_waddr, hd_raddr;
    logic [LW-1:0] hd_wdata, hd_rd;
    logic          tl_we;
    logic [CW-1:0] tl_waddr, tl_raddr;
    logic [LW-1:0] tl_wdata, tl_rd;

    // Derived values.
    logic [CW-1:0] lu_len;
    logic          lu_used;
    logic [SW-1:0] nb_page;
    logic [BW-1:0] bound;
    logic          fresh_short;
    logic          pg_ok;
    logic [LW-1:0] push_tail;
    logic          go_fmark;

    assign lu_len      = lu_rd[CW:1];
    assign lu_used     = lu_rd[0];
    assign nb_page     = SW'(s_reg) + SW'(len_reg);
    assign bound       = (BW'(limit_reg) < BW'(POOL_PAGES)) ? BW'(limit_reg) : BW'(POOL_PAGES);
    assign fresh_short = (BW'(fresh_reg) > bound) || ((bound - BW'(fresh_reg)) < BW'(cnt_reg));
    assign pg_ok       = (32'(page_number) < POOL_PAGES) && (32'(page_number) < 32'(fresh_reg));
    assign push_tail   = nonempty_reg[plen_reg] ? tl_rd : NIL;

    // Memories: owner start per page, header per run start, links, list ends.
    psa_ram #(.WIDTH(PW), .DEPTH(POOL_PAGES)) u_owner (
        .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rd)
    );
    psa_ram #(.WIDTH(CW + 1), .DEPTH(POOL_PAGES)) u_lenuse (
        .clk(clk), .we(lu_we), .waddr(lu_waddr), .wdata(lu_wdata),
        .raddr(lu_raddr), .rdata(lu_rd)
    );
    psa_ram #(.WIDTH(LW), .DEPTH(POOL_PAGES)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rd)
    );
    psa_ram #(.WIDTH(LW), .DEPTH(POOL_PAGES)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rd)
    );
    psa_ram #(.WIDTH(LW), .DEPTH(MAX_RUN + 1)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rd)
    );
    psa_ram #(.WIDTH(LW), .DEPTH(MAX_RUN + 1)) u_tail (
        .clk(clk), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
        .raddr(tl_raddr), .rdata(tl_rd)
    );

    // Next state and working register updates.
    always_comb
    begin
        state_next      = state_reg;
        nonempty_next   = nonempty_reg;
        fresh_next      = fresh_reg;
        cnt_next        = cnt_reg;
        pg_next         = pg_reg;
        scan_next       = scan_reg;
        s_next          = s_reg;
        len_next        = len_reg;
        q_next          = q_reg;
        rs_next         = rs_reg;
        rlen_next       = rlen_reg;
        ret_next        = ret_reg;
        ms_next         = ms_reg;
        mlen_next       = mlen_reg;
        mused_next      = mused_reg;
        k_next          = k_reg;
        mret_next       = mret_reg;
        ps_next         = ps_reg;
        plen_next       = plen_reg;
        t_next          = t_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_pages_next  = res_pages_reg;
        go_fmark        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next        = CW'(req_pages);
                    pg_next         = PW'(page_number);
                    res_status_next = STAT_NOT_FOUND;
                    res_start_next  = '0;
                    res_pages_next  = '0;
                    if (action == ACT_ALLOC)
                    begin
                        if (req_pages == '0 || 32'(req_pages) > MAX_RUN)
                        begin
                            res_status_next = STAT_BAD_SIZE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            scan_next  = CW'(req_pages);
                            state_next = ST_ALLOC_SCAN;
                        end
                    end
                    else if (action == ACT_FREE && pg_ok)
                    begin
                        state_next = ST_FREE_RD;
                    end
                    else if (action == ACT_LOOK && pg_ok)
                    begin
                        state_next = ST_LOOK_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // One list length per cycle, smallest first.
            ST_ALLOC_SCAN:
            begin
                if (nonempty_reg[scan_reg])
                begin
                    state_next = ST_ALLOC_HEAD;
                end
                else if (32'(scan_reg) != MAX_RUN)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                else if (fresh_short)
                begin
                    res_status_next = STAT_NO_PAGES;
                    state_next      = ST_DONE;
                end
                else
                begin
                    ms_next         = PW'(fresh_reg);
                    mlen_next       = cnt_reg;
                    mused_next      = 1'b1;
                    k_next          = '0;
                    mret_next       = MK_TO_DONE;
                    fresh_next      = fresh_reg + LW'(cnt_reg);
                    res_status_next = STAT_OK;
                    res_start_next  = START_W'(fresh_reg);
                    res_pages_next  = PAGES_W'(cnt_reg);
                    state_next      = ST_MARK;
                end
            end

            ST_ALLOC_HEAD:
            begin
                rs_next    = PW'(hd_rd);
                rlen_next  = scan_reg;
                ret_next   = RM_TO_AMARK;
                state_next = ST_RM_RD;
            end

            ST_RM_RD:
            begin
                state_next = ST_RM_WR;
            end

            // Unlink the run; the list empties when it was the head and had no successor.
            ST_RM_WR:
            begin
                if (pv_rd == NIL)
                begin
                    nonempty_next[rlen_reg] = (nx_rd != NIL);
                end
                unique case (ret_reg)
                    RM_TO_AMARK:
                    begin
                        ms_next         = rs_reg;
                        mlen_next       = cnt_reg;
                        mused_next      = 1'b1;
                        k_next          = '0;
                        mret_next       = (scan_reg != cnt_reg) ? MK_TO_REM : MK_TO_DONE;
                        res_status_next = STAT_OK;
                        res_start_next  = START_W'(rs_reg);
                        res_pages_next  = PAGES_W'(cnt_reg);
                        state_next      = ST_MARK;
                    end
                    RM_TO_FNX:
                    begin
                        state_next = ST_FREE_NX;
                    end
                    RM_TO_FMARK:
                    begin
                        go_fmark = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Page map sweep, one page per cycle.
            ST_MARK:
            begin
                k_next = k_reg + CW'(1);
                if (k_reg == mlen_reg - CW'(1))
                begin
                    unique case (mret_reg)
                        MK_TO_DONE:
                        begin
                            state_next = ST_DONE;
                        end
                        MK_TO_REM:
                        begin
                            ms_next    = ms_reg + PW'(cnt_reg);
                            mlen_next  = scan_reg - cnt_reg;
                            mused_next = 1'b0;
                            k_next     = '0;
                            mret_next  = MK_TO_PUSH;
                        end
                        MK_TO_PUSH:
                        begin
                            ps_next    = ms_reg;
                            plen_next  = mlen_reg;
                            state_next = ST_PUSH_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PUSH_RD:
            begin
                state_next = ST_PUSH_WR;
            end

            ST_PUSH_WR:
            begin
                t_next                  = push_tail;
                nonempty_next[plen_reg] = 1'b1;
                state_next              = (push_tail != NIL) ? ST_PUSH_LINK : ST_DONE;
            end

            ST_PUSH_LINK:
            begin
                state_next = ST_DONE;
            end

            ST_FREE_RD:
            begin
                state_next = ST_FREE_CHK;
            end

            // Must be the first page of an in-use run.
            ST_FREE_CHK:
            begin
                if (own_rd == pg_reg && lu_used)
                begin
                    s_next     = pg_reg;
                    len_next   = lu_len;
                    state_next = (pg_reg != '0) ? ST_FREE_PQ : ST_FREE_NX;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_FREE_PQ:
            begin
                q_next     = own_rd;
                state_next = ST_FREE_PL;
            end

            // Merge with a free run that ends right before this one.
            ST_FREE_PL:
            begin
                if (!lu_used && (SW'(q_reg) + SW'(lu_len) == SW'(s_reg)) &&
                    (SW'(lu_len) + SW'(len_reg) <= SW'(MAX_RUN)))
                begin
                    rs_next    = q_reg;
                    rlen_next  = lu_len;
                    s_next     = q_reg;
                    len_next   = len_reg + lu_len;
                    ret_next   = RM_TO_FNX;
                    state_next = ST_RM_RD;
                end
                else
                begin
                    state_next = ST_FREE_NX;
                end
            end

            ST_FREE_NX:
            begin
                if (nb_page < SW'(POOL_PAGES) && nb_page < SW'(fresh_reg))
                begin
                    q_next     = PW'(nb_page);
                    state_next = ST_FREE_NL;
                end
                else
                begin
                    go_fmark = 1'b1;
                end
            end

            // Merge with a free run that starts right after this one.
            ST_FREE_NL:
            begin
                if (own_rd == q_reg && !lu_used &&
                    (SW'(lu_len) + SW'(len_reg) <= SW'(MAX_RUN)))
                begin
                    rs_next    = q_reg;
                    rlen_next  = lu_len;
                    len_next   = len_reg + lu_len;
                    ret_next   = RM_TO_FMARK;
                    state_next = ST_RM_RD;
                end
                else
                begin
                    go_fmark = 1'b1;
                end
            end

            ST_LOOK_RD:
            begin
                state_next = ST_LOOK_OW;
            end

            ST_LOOK_OW:
            begin
                s_next     = own_rd;
                state_next = ST_LOOK_LU;
            end

            ST_LOOK_LU:
            begin
                if (lu_used)
                begin
                    res_status_next = STAT_OK;
                    res_start_next  = START_W'(s_reg);
                    res_pages_next  = PAGES_W'(lu_len);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Freed run is remapped as free, then pushed onto its list.
        if (go_fmark)
        begin
            ms_next         = s_reg;
            mlen_next       = len_reg;
            mused_next      = 1'b0;
            k_next          = '0;
            mret_next       = MK_TO_PUSH;
            res_status_next = STAT_OK;
            res_start_next  = START_W'(s_reg);
            res_pages_next  = PAGES_W'(len_reg);
            state_next      = ST_MARK;
        end
    end

    // Memory port controls.
    always_comb
    begin
        own_we    = 1'b0;
        own_waddr = ms_reg + PW'(k_reg);
        own_wdata = ms_reg;
        own_raddr = pg_reg;
        lu_we     = 1'b0;
        lu_waddr  = ms_reg;
        lu_wdata  = {mlen_reg, mused_reg};
        lu_raddr  = pg_reg;
        nx_we     = 1'b0;
        nx_waddr  = PW'(pv_rd);
        nx_wdata  = nx_rd;
        nx_raddr  = rs_reg;
        pv_we     = 1'b0;
        pv_waddr  = PW'(nx_rd);
        pv_wdata  = pv_rd;
        pv_raddr  = rs_reg;
        hd_we     = 1'b0;
        hd_waddr  = rlen_reg;
        hd_wdata  = nx_rd;
        hd_raddr  = scan_reg;
        tl_we     = 1'b0;
        tl_waddr  = rlen_reg;
        tl_wdata  = pv_rd;
        tl_raddr  = plen_reg;

        unique case (state_reg)
            ST_FREE_CHK:
            begin
                own_raddr = pg_reg - PW'(1);
            end
            ST_FREE_PQ, ST_LOOK_OW:
            begin
                lu_raddr = own_rd;
            end
            ST_FREE_NX:
            begin
                own_raddr = PW'(nb_page);
                lu_raddr  = PW'(nb_page);
            end
            ST_RM_WR:
            begin
                nx_we = (pv_rd != NIL);
                pv_we = (nx_rd != NIL);
                hd_we = (pv_rd == NIL);
                tl_we = (nx_rd == NIL);
            end
            ST_MARK:
            begin
                own_we = 1'b1;
                lu_we  = (k_reg == '0);
            end
            ST_PUSH_WR:
            begin
                nx_we    = 1'b1;
                nx_waddr = ps_reg;
                nx_wdata = NIL;
                pv_we    = 1'b1;
                pv_waddr = ps_reg;
                pv_wdata = push_tail;
                tl_we    = 1'b1;
                tl_waddr = plen_reg;
                tl_wdata = LW'(ps_reg);
                hd_we    = (push_tail == NIL);
                hd_waddr = plen_reg;
                hd_wdata = LW'(ps_reg);
            end
            ST_PUSH_LINK:
            begin
                nx_we    = 1'b1;
                nx_waddr = PW'(t_reg);
                nx_wdata = LW'(ps_reg);
            end
            default:
            begin
                own_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            nonempty_reg <= '0;
            fresh_reg    <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        pg_reg         <= pg_next;
        scan_reg       <= scan_next;
        s_reg          <= s_next;
        len_reg        <= len_next;
        q_reg          <= q_next;
        rs_reg         <= rs_next;
        rlen_reg       <= rlen_next;
        ret_reg        <= ret_next;
        ms_reg         <= ms_next;
        mlen_reg       <= mlen_next;
        mused_reg      <= mused_next;
        k_reg          <= k_next;
        mret_reg       <= mret_next;
        ps_reg         <= ps_next;
        plen_reg       <= plen_next;
        t_reg          <= t_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_pages_reg  <= res_pages_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign status    = res_status_reg;
    assign run_start = res_start_reg;
    assign run_pages = res_pages_reg;

endmodule

`default_nettype wire

// ===== rtl/psa_check.sv =====
// Port-level checker for the page span allocator, bound to the top level.
// Depends on psa_pkg and page_span_allocator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "page_span_allocator_assert.svh"

module psa_check
    import psa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [START_W-1:0]  run_start,
    input wire logic [PAGES_W-1:0]  run_pages
);

    `PSA_ASSERT_ALWAYS(a_no_done_in_reset, !rst_n |-> !done, "done during reset")
    `PSA_ASSERT_RUN(a_accept_busy, (start && !busy) |=> busy, "accepted request without busy")
    `PSA_ASSERT_RUN(a_done_while_busy, done |-> busy, "result beat outside a request")
    `PSA_ASSERT_RUN(a_done_releases, done |=> !busy, "busy held after the result beat")
    `PSA_ASSERT_RUN(a_fail_zero, (done && status != STAT_OK) |-> (run_start == '0 && run_pages == '0), "failed result carries a run")

endmodule

bind page_span_allocator psa_check u_psa_check (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .status(status),
    .run_start(run_start),
    .run_pages(run_pages)
);

`default_nettype wire
